>>> design/smatch_pkg.sv
`default_nettype none
package smatch_pkg;
  localparam int MaxPeople = 16;
  localparam int PW = 4;
  localparam logic [1:0] OP_LOAD_PROP = 2'd0;
  localparam logic [1:0] OP_LOAD_RECV = 2'd1;
  localparam logic [1:0] OP_RUN       = 2'd2;
endpackage
`default_nettype wire

>>> design/smatch_if.sv
`default_nettype none
interface smatch_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] person;
  logic [3:0] rank;
  logic [3:0] choice;
  modport source (output valid, operation, person, rank, choice, input ready);
  modport sink (input valid, operation, person, rank, choice, output ready);
endinterface

interface smatch_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] receiver;
  logic [3:0] partner;
  logic       partner_valid;
  logic       last;
  modport source (output valid, receiver, partner, partner_valid, last, input ready);
  modport sink (input valid, receiver, partner, partner_valid, last, output ready);
endinterface

interface smatch_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> design/stable_matching_engine.sv
// Loads: accepted while idle, no result.
// Run: each proposal reads the proposer list and, if the receiver is taken,
// scans her list (n reads). After the run, n results follow, one per cycle
// while out_ch.ready is high.
// Input stalls from the run transfer until the last result transfers.
// Reset (synchronous, rst_n low): idle, participants = 16; lists undefined.
`default_nettype none
module stable_matching_engine import smatch_pkg::*; #(
  parameter int MAX_PEOPLE = MaxPeople
) (
  input wire logic clk,
  input wire logic rst_n,
  smatch_in_if.sink    in_ch,
  smatch_out_if.source out_ch,
  smatch_cfg_if.sink   cfg_ch
);
  localparam int IW = $clog2(MAX_PEOPLE);
  localparam int AW = 2 * IW;
  localparam int NW = IW + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_PREAD = 3'd1, S_PWAIT = 3'd2,
                         S_RREAD = 3'd3, S_RWAIT = 3'd4, S_NEXT = 3'd5, S_OUT = 3'd6;

  logic [2:0]    st_r, st_nxt;
  logic [4:0]    part_r;
  logic [NW-1:0] n_r;
  logic [IW-1:0] m_r, f_r, w_r, i_r, cur_r, rcnt_r;
  logic          rn_found_r, rc_found_r, changed_r;
  logic [NW-1:0] rn_r, rc_r, eng_cnt_r;
  logic [MAX_PEOPLE-1:0] taken_r, engaged_r;
  logic [IW-1:0] partner_r [MAX_PEOPLE];

  logic          pwe, rwe;
  logic [AW-1:0] waddr, praddr, rraddr;
  logic [PW-1:0] prdata, rrdata;

  smatch_mem #(.AW(AW)) u_pmem (.clk, .we(pwe), .waddr, .wdata(in_ch.choice),
    .raddr(praddr), .rdata(prdata));
  smatch_mem #(.AW(AW)) u_rmem (.clk, .we(rwe), .waddr, .wdata(in_ch.choice),
    .raddr(rraddr), .rdata(rrdata));

  logic in_xfer, in_ok;
  assign in_ch.ready = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_ok = (int'(in_ch.person) < MAX_PEOPLE) && (int'(in_ch.rank) < MAX_PEOPLE);
  assign waddr = {IW'(in_ch.person), IW'(in_ch.rank)};
  assign pwe = in_xfer && in_ok && in_ch.operation == OP_LOAD_PROP;
  assign rwe = in_xfer && in_ok && in_ch.operation == OP_LOAD_RECV;
  assign praddr = {m_r, f_r};
  assign rraddr = {w_r, i_r};

  logic [NW-1:0] n_eff;
  always_comb begin
    if (part_r == 5'd0) n_eff = NW'(1);
    else if (int'(part_r) > MAX_PEOPLE) n_eff = NW'(MAX_PEOPLE);
    else n_eff = NW'(part_r);
  end

  logic [NW-1:0] rn_fin, rc_fin;
  logic          win;
  always_comb begin
    rn_fin = rn_r;
    rc_fin = rc_r;
    if (!rn_found_r && int'(rrdata) == int'(m_r)) rn_fin = NW'(i_r);
    if (!rc_found_r && int'(rrdata) == int'(cur_r)) rc_fin = NW'(i_r);
    win = (rn_fin < n_r) && (rn_fin < rc_fin);
  end

  logic          last_f, last_m, scan_end, choice_ok, take_new, swap;
  logic          prop_done, pass_chg, run_done;
  logic [IW-1:0] w_sel;
  logic [NW-1:0] cnt_now;
  assign last_f = (NW'(f_r) + NW'(1) >= n_r);
  assign last_m = (NW'(m_r) + NW'(1) >= n_r);
  assign scan_end = (NW'(i_r) + NW'(1) >= n_r);
  assign choice_ok = (int'(prdata) < int'(n_r));
  assign w_sel = IW'(prdata);
  assign take_new = (st_r == S_PWAIT) && choice_ok && !taken_r[w_sel];
  assign swap = (st_r == S_RWAIT) && scan_end && win;
  assign prop_done = ((st_r == S_NEXT) && engaged_r[m_r]) ||
                     ((st_r == S_PWAIT) && (take_new || (!choice_ok && last_f))) ||
                     ((st_r == S_RWAIT) && scan_end && (win || last_f));
  assign pass_chg = changed_r || take_new || swap;
  assign cnt_now = take_new ? eng_cnt_r + NW'(1) : eng_cnt_r;
  assign run_done = prop_done && last_m && (cnt_now == n_r || !pass_chg);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (in_xfer && in_ch.operation == OP_RUN) st_nxt = S_NEXT;
      S_NEXT:  st_nxt = prop_done ? (run_done ? S_OUT : S_NEXT) : S_PREAD;
      S_PREAD: st_nxt = S_PWAIT;
      S_PWAIT: begin
        if (prop_done) st_nxt = run_done ? S_OUT : S_NEXT;
        else if (choice_ok) st_nxt = S_RREAD;
        else st_nxt = S_PREAD;
      end
      S_RREAD: st_nxt = S_RWAIT;
      S_RWAIT: begin
        if (!scan_end) st_nxt = S_RREAD;
        else if (prop_done) st_nxt = run_done ? S_OUT : S_NEXT;
        else st_nxt = S_PREAD;
      end
      S_OUT:   if (out_ch.ready && NW'(rcnt_r) + NW'(1) >= n_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // S_NEXT: pick the next free proposer from m_r; S_PWAIT: choice in prdata
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      part_r <= 5'd16;
    end else begin
      st_r <= st_nxt;
      if (cfg_ch.valid) part_r <= cfg_ch.data;
      if (in_xfer && in_ch.operation == OP_RUN) begin
        n_r <= n_eff;
        taken_r <= '0;
        engaged_r <= '0;
        eng_cnt_r <= '0;
        changed_r <= 1'b0;
        m_r <= '0;
        f_r <= '0;
      end
      if (take_new) begin
        taken_r[w_sel] <= 1'b1;
        partner_r[w_sel] <= m_r;
        engaged_r[m_r] <= 1'b1;
        eng_cnt_r <= cnt_now;
      end
      if (st_r == S_PWAIT && choice_ok && !take_new) begin
        w_r <= w_sel;
        cur_r <= partner_r[w_sel];
        i_r <= '0;
        rn_r <= n_r;
        rc_r <= n_r;
        rn_found_r <= 1'b0;
        rc_found_r <= 1'b0;
      end
      if (st_r == S_RWAIT) begin
        rn_r <= rn_fin;
        rc_r <= rc_fin;
        rn_found_r <= rn_found_r || int'(rrdata) == int'(m_r);
        rc_found_r <= rc_found_r || int'(rrdata) == int'(cur_r);
        if (!scan_end) i_r <= i_r + 1'b1;
      end
      if (swap) begin
        engaged_r[cur_r] <= 1'b0;
        engaged_r[m_r] <= 1'b1;
        partner_r[w_r] <= m_r;
      end
      if (prop_done) begin
        f_r <= '0;
        changed_r <= pass_chg && !last_m;
        if (!last_m) m_r <= m_r + 1'b1;
        else if (!run_done) m_r <= '0;
        if (run_done) rcnt_r <= '0;
      end else if ((st_r == S_PWAIT && !choice_ok) || (st_r == S_RWAIT && scan_end)) begin
        f_r <= f_r + 1'b1;
      end
      if (st_r == S_OUT && out_ch.ready) rcnt_r <= rcnt_r + 1'b1;
    end
  end

  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.receiver = 4'(rcnt_r);
  assign out_ch.partner_valid = taken_r[rcnt_r];
  assign out_ch.partner = taken_r[rcnt_r] ? 4'(partner_r[rcnt_r]) : 4'd0;
  assign out_ch.last = (NW'(rcnt_r) + NW'(1) >= n_r);
endmodule
`default_nettype wire

>>> design/smatch_mem.sv
`default_nettype none
module smatch_mem import smatch_pkg::*; #(
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [PW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [PW-1:0] rdata
);
  logic [PW-1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/smatch_checker.sv
`default_nettype none
module smatch_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic [3:0] out_receiver
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept during output");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_receiver == 4'd0) else $error("first receiver not 0");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_receiver == $past(out_receiver) + 4'd1)
    else $error("receiver sequence");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid) else $error("output after last");
endmodule

bind stable_matching_engine smatch_checker u_chk (.clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_last(out_ch.last), .out_receiver(out_ch.receiver));
`default_nettype wire

>>> test/stable_matching_engine_tb.sv
`timescale 1ns / 1ps
module stable_matching_engine_tb;
  import smatch_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IdleLimit = 1000000;
  localparam int HoldCycles = 400;
  localparam int TargetItems = 410;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] person;
    logic [3:0] rank;
    logic [3:0] choice;
  } pref_item_t;

  typedef struct packed {
    logic [3:0] receiver;
    logic [3:0] partner;
    logic       partner_valid;
    logic       last;
  } pairing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  smatch_in_if  in_if();
  smatch_out_if out_if();
  smatch_cfg_if cfg_if();

  stable_matching_engine uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #5 clk = ~clk;

  pref_item_t pend_q[$];
  pairing_t   pairing_q[$];
  int         errors = 0;
  int         items_queued = 0;
  bit         hold_arm = 1'b0;

  // predictor state
  logic [3:0] prop_list[MaxPeople][MaxPeople];
  logic [3:0] recv_list[MaxPeople][MaxPeople];
  int         people_n = 16;

  // stimulus bookkeeping of written list entries
  bit prop_set[MaxPeople][MaxPeople];
  bit recv_set[MaxPeople][MaxPeople];

  function automatic int recv_rank_of(int w, int who, int n);
    for (int i = 0; i < n; i++) begin
      if (recv_list[w][i] == who) return i;
    end
    return n;
  endfunction

  task automatic predict_pairings();
    bit         taken[MaxPeople];
    bit         engaged[MaxPeople];
    logic [3:0] mate[MaxPeople];
    int         n, cnt, w, cur, rn;
    bit         changed;
    pairing_t   res;
    n = people_n;
    cnt = 0;
    changed = 1'b1;
    for (int i = 0; i < MaxPeople; i++) begin
      taken[i] = 1'b0;
      engaged[i] = 1'b0;
      mate[i] = '0;
    end
    while (cnt != n && changed) begin
      changed = 1'b0;
      for (int m = 0; m < n; m++) begin
        for (int f = 0; f < n && !engaged[m]; f++) begin
          w = prop_list[m][f];
          if (w >= n) continue;
          if (!taken[w]) begin
            taken[w] = 1'b1;
            mate[w] = m[3:0];
            engaged[m] = 1'b1;
            cnt++;
            changed = 1'b1;
          end else begin
            cur = mate[w];
            rn = recv_rank_of(w, m, n);
            if (rn < n && rn < recv_rank_of(w, cur, n)) begin
              engaged[cur] = 1'b0;
              mate[w] = m[3:0];
              engaged[m] = 1'b1;
              changed = 1'b1;
            end
          end
        end
      end
    end
    for (int r = 0; r < n; r++) begin
      res.receiver = r[3:0];
      res.partner = taken[r] ? mate[r] : 4'd0;
      res.partner_valid = taken[r];
      res.last = (r + 1 == n);
      pairing_q.push_back(res);
    end
  endtask

  task automatic apply_item(pref_item_t it);
    case (it.op)
      OP_LOAD_PROP: prop_list[it.person][it.rank] = it.choice;
      OP_LOAD_RECV: recv_list[it.person][it.rank] = it.choice;
      OP_RUN: predict_pairings();
      default: ;
    endcase
  endtask

  // driver
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    pref_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_item({in_if.operation, in_if.person, in_if.rank, in_if.choice});
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          nxt = pend_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.operation <= nxt.op;
          in_if.person <= nxt.person;
          in_if.rank <= nxt.rank;
          in_if.choice <= nxt.choice;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  int hold_left = 0;
  bit hold_done = 1'b0;
  int phase_cnt = 0;
  bit steady = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_arm && !hold_done && out_if.valid) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= (hold_left == 0);
    end else begin
      phase_cnt++;
      if (phase_cnt == 48) begin
        phase_cnt = 0;
        steady = ($urandom_range(0, 2) == 0);
      end
      out_if.ready <= steady || ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    pairing_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pairing_q.size() == 0) begin
        $error("unexpected result receiver %0d", out_if.receiver);
        errors++;
      end else begin
        want = pairing_q.pop_front();
        if (out_if.receiver !== want.receiver) begin
          $error("receiver expected %0d actual %0d", want.receiver, out_if.receiver);
          errors++;
        end
        if (out_if.partner !== want.partner) begin
          $error("partner expected %0d actual %0d", want.partner, out_if.partner);
          errors++;
        end
        if (out_if.partner_valid !== want.partner_valid) begin
          $error("partner_valid expected %0d actual %0d", want.partner_valid,
                 out_if.partner_valid);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_if.last);
          errors++;
        end
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add(logic [1:0] op, int p, int r, int c);
    pend_q.push_back({op, p[3:0], r[3:0], c[3:0]});
    items_queued++;
    if (op == OP_LOAD_PROP) prop_set[p][r] = 1'b1;
    if (op == OP_LOAD_RECV) recv_set[p][r] = 1'b1;
  endtask

  task automatic settle();
    @(posedge clk);
    while (pend_q.size() != 0 || in_if.valid || pairing_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_participants(int v);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v[4:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    people_n = (v == 0) ? 1 : ((v > MaxPeople) ? MaxPeople : v);
  endtask

  task automatic load_lists(int n, bit well_formed);
    int perm[MaxPeople];
    int j, t;
    for (int side = 0; side < 2; side++) begin
      for (int p = 0; p < n; p++) begin
        if (well_formed) begin
          for (int i = 0; i < n; i++) perm[i] = i;
          for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
          end
          for (int i = 0; i < n; i++) begin
            add(side ? OP_LOAD_RECV : OP_LOAD_PROP, p, i, perm[i]);
          end
        end else begin
          for (int i = 0; i < n; i++) begin
            if (!(side ? recv_set[p][i] : prop_set[p][i]) || $urandom_range(0, 2) == 0) begin
              add(side ? OP_LOAD_RECV : OP_LOAD_PROP, p, i,
                  $urandom_range(0, 1) ? $urandom_range(0, n - 1) : $urandom_range(0, 15));
            end
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          add(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
        end
      end
    end
  endtask

  initial begin
    int n;
    in_if.valid = 1'b0;
    in_if.operation = OP_LOAD_PROP;
    in_if.person = '0;
    in_if.rank = '0;
    in_if.choice = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    add(OP_UNUSED, 15, 15, 15);
    add(OP_LOAD_RECV, 15, 15, 15);
    write_participants(0);
    add(OP_LOAD_PROP, 0, 0, 0);
    add(OP_LOAD_RECV, 0, 0, 0);
    add(OP_RUN, 0, 0, 0);

    write_participants(2);
    add(OP_LOAD_PROP, 0, 0, 15);
    add(OP_LOAD_PROP, 0, 1, 1);
    add(OP_LOAD_PROP, 1, 0, 1);
    add(OP_LOAD_PROP, 1, 1, 0);
    add(OP_LOAD_RECV, 0, 0, 1);
    add(OP_LOAD_RECV, 0, 1, 1);
    add(OP_LOAD_RECV, 1, 0, 0);
    add(OP_LOAD_RECV, 1, 1, 1);
    add(OP_RUN, 0, 0, 0);
    add(OP_LOAD_PROP, 0, 0, 0);
    add(OP_LOAD_PROP, 0, 1, 0);
    add(OP_LOAD_PROP, 1, 0, 0);
    add(OP_LOAD_PROP, 1, 1, 0);
    add(OP_RUN, 0, 0, 0);

    write_participants(16);
    for (int m = 0; m < MaxPeople; m++) add(OP_LOAD_PROP, m, 0, 15 - m);
    add(OP_RUN, 0, 0, 0);

    while (items_queued < TargetItems) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
      write_participants(($urandom_range(0, 15) == 0) ? 0 : n);
      n = people_n;
      load_lists(n, $urandom_range(0, 3) != 0);
      add(OP_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
      if (!hold_done) begin
        hold_arm = 1'b1;
        add(OP_RUN, 0, 0, 0);
      end
      for (int k = $urandom_range(0, 2); k > 0; k--) begin
        for (int e = $urandom_range(1, 4); e > 0; e--) begin
          add($urandom_range(0, 1) ? OP_LOAD_RECV : OP_LOAD_PROP, $urandom_range(0, n - 1),
              $urandom_range(0, n - 1), $urandom_range(0, 15));
        end
        add(OP_RUN, 0, 0, 0);
      end
    end

    settle();
    repeat (50) @(posedge clk);
    if (errors == 0 && pairing_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
